>>> src/a64lsu_pkg.sv
package a64lsu_pkg;

   // request codes
   typedef enum logic [2:0] {
      ACT_EXECUTE   = 3'd0,
      ACT_WRITE_MEM = 3'd1,
      ACT_WRITE_REG = 3'd2,
      ACT_READ_REG  = 3'd3,
      ACT_READ_MEM  = 3'd4
   } action_type;

   localparam int          NUM_REGS = 31;
   localparam int          LANES    = 8;
   localparam logic [4:0]  REG_ZERO = 5'd31;
   localparam logic [63:0] PC_STEP  = 64'd4;

endpackage

>>> src/aarch64_load_store_unit_core.sv
// AArch64 LDR/STR execution core with its own 31 x 64-bit register file, byte-addressed
// little-endian data memory and program counter. A request is taken when start is high and
// busy is low; its single response appears on the rsp_ ports for exactly one cycle with
// rsp_valid high and cannot be held off, so the receiver must take it then. Steps from
// acceptance to the next possible acceptance: for stores a register file read, address
// add and one access of the memory lanes, for loads the same and a register write back,
// for register and memory byte reads a read step, and none more for register and memory
// byte writes and unused codes. The response is on the rsp_ ports once busy is low again,
// and the next request may be accepted at the edge that ends it. The data memory is eight
// byte-wide lane RAMs of MEMORY_BYTES/8 rows each, so an unaligned 4- or 8-byte access
// touches at most two rows in one lane access. After reset the block clears the data
// memory one row per cycle, all MEMORY_BYTES/8 rows, with busy held high. MEMORY_BYTES
// must be a power of two of at least 256.
module aarch64_load_store_unit_core #(
   parameter int MEMORY_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_instruction,
   input  logic [4:0]  req_reg_index,
   input  logic [15:0] req_mem_address,
   input  logic [63:0] req_write_value,
   output logic        rsp_valid,
   output logic [63:0] rsp_read_value,
   output logic        rsp_status,
   output logic [63:0] rsp_pc_value
);
   import a64lsu_pkg::*;

   localparam int ROWS  = MEMORY_BYTES / LANES;
   localparam int ROW_W = $clog2(ROWS);
   localparam int AW    = ROW_W + 3;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ADDR,
      S_MEM,
      S_LOAD,
      S_RDREG,
      S_RDMEM
   } state_type;

   state_type state_ff;

   // request context
   logic [31:0]      ins_ff;
   logic [63:0]      addr_ff;
   logic [63:0]      moved_ff;
   logic             fwd_ff;
   logic             fault_ff;
   logic             ma_ok_ff;
   logic [ROW_W-1:0] clear_row_ff;
   logic [63:0]      pc_ff;

   // response registers
   logic        rsp_valid_ff;
   logic [63:0] rsp_read_value_ff;
   logic        rsp_status_ff;
   logic [63:0] rsp_pc_value_ff;

   action_type req_act;
   logic       accept;

   // register file: sync read, two read ports, one write port
   logic [63:0]         rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0] rf_valid_ff;
   logic [4:0]          rfa_addr;
   logic [4:0]          rfb_addr;
   logic [63:0]         rfa_ff;
   logic [63:0]         rfb_ff;
   logic                rfa_ok_ff;
   logic                rfb_ok_ff;
   logic [63:0]         a_val;
   logic [63:0]         b_val;
   logic                rf_we;
   logic [4:0]          rf_waddr;
   logic [63:0]         rf_wd;

   // byte lanes
   logic [LANES-1:0] lane_we;
   logic [ROW_W-1:0] lane_row [LANES];
   logic [7:0]       lane_wd  [LANES];
   logic [7:0]       lane_rd_ff [LANES];

   // decode and datapath
   logic [63:0]      ma_ext;
   logic             ma_ok;
   logic             size8;
   logic             is_load;
   logic             wb;
   logic [63:0]      imm19_off;
   logic [63:0]      imm12_off;
   logic [63:0]      simm9;
   logic [63:0]      moved;
   logic [63:0]      addr_in;
   logic             fault;
   logic [2:0]       off;
   logic [ROW_W-1:0] row;
   logic [ROW_W-1:0] row_next;
   logic [63:0]      st_data;
   logic [63:0]      ld_raw;
   logic [63:0]      ld_val;

   assign req_act = action_type'(req_action);
   assign busy    = reset || (state_ff != S_IDLE);
   assign accept  = start && !busy;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_pc_value   = rsp_pc_value_ff;

   // byte request address
   assign ma_ext = {48'b0, req_mem_address};
   assign ma_ok  = ma_ext < 64'(MEMORY_BYTES);

   // register read values, entry 31 and never-written entries read as zero
   assign a_val = rfa_ok_ff ? rfa_ff : 64'b0;
   assign b_val = rfb_ok_ff ? rfb_ff : 64'b0;

   // instruction fields
   assign size8     = ins_ff[30];
   assign is_load   = !ins_ff[31] || ins_ff[22];
   assign wb        = ins_ff[31] && !ins_ff[24] && !ins_ff[21];
   assign imm19_off = {{43{ins_ff[23]}}, ins_ff[23:5], 2'b00};
   assign imm12_off = size8 ? {49'b0, ins_ff[21:10], 3'b000} : {50'b0, ins_ff[21:10], 2'b00};
   assign simm9     = {{55{ins_ff[20]}}, ins_ff[20:12]};
   assign moved     = a_val + simm9;

   // effective address, at most one add per form
   always_comb begin
      if (!ins_ff[31]) begin
         addr_in = pc_ff + imm19_off;
      end else if (ins_ff[24]) begin
         addr_in = a_val + imm12_off;
      end else if (ins_ff[21]) begin
         addr_in = a_val + b_val;
      end else if (ins_ff[11]) begin
         addr_in = moved;
      end else begin
         addr_in = a_val;
      end
   end

   // access must end inside memory
   assign fault    = addr_ff > (64'(MEMORY_BYTES) - (size8 ? 64'd8 : 64'd4));
   assign off      = addr_ff[2:0];
   assign row      = addr_ff[AW-1:3];
   assign row_next = row + 1'b1;

   // store data: take the written-back base when the store source is that same register
   assign st_data = fwd_ff ? moved_ff : a_val;

   // load assembly from the lanes read in the memory step
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         ld_raw[8*k +: 8] = lane_rd_ff[3'(k) + off];
      end
      ld_val = size8 ? ld_raw : {32'b0, ld_raw[31:0]};
   end

   // register file read addresses
   always_comb begin
      if (state_ff == S_IDLE) begin
         rfa_addr = (req_act == ACT_READ_REG) ? req_reg_index : req_instruction[9:5];
      end else begin
         rfa_addr = ins_ff[4:0];
      end
      rfb_addr = req_instruction[20:16];
   end

   // register file write port: register write request, base write back, load result
   always_comb begin
      rf_we    = 1'b0;
      rf_waddr = ins_ff[4:0];
      rf_wd    = ld_val;
      case (state_ff)
         S_IDLE: begin
            rf_we    = accept && (req_act == ACT_WRITE_REG);
            rf_waddr = req_reg_index;
            rf_wd    = req_write_value;
         end
         S_ADDR: begin
            rf_we    = wb;
            rf_waddr = ins_ff[9:5];
            rf_wd    = moved;
         end
         S_LOAD: begin
            rf_we    = !fault_ff;
            rf_waddr = ins_ff[4:0];
            rf_wd    = ld_val;
         end
         default: begin
            rf_we = 1'b0;
         end
      endcase
      if (rf_waddr == REG_ZERO) begin
         rf_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_waddr] <= rf_wd;
      end
      rfa_ff    <= rf_mem[rfa_addr];
      rfb_ff    <= rf_mem[rfb_addr];
      rfa_ok_ff <= (rfa_addr != REG_ZERO) && rf_valid_ff[rfa_addr];
      rfb_ok_ff <= (rfb_addr != REG_ZERO) && rf_valid_ff[rfb_addr];
   end

   // per-entry valid bits stand in for clearing the register file
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else if (rf_we) begin
         rf_valid_ff[rf_waddr] <= 1'b1;
      end
   end

   // lane control: clear sweep, byte write/read, unaligned word access
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         lane_we[j]  = 1'b0;
         lane_row[j] = row;
         lane_wd[j]  = 8'b0;
         case (state_ff)
            S_CLEAR: begin
               lane_we[j]  = 1'b1;
               lane_row[j] = clear_row_ff;
            end
            S_IDLE: begin
               lane_row[j] = ma_ext[AW-1:3];
               lane_wd[j]  = req_write_value[7:0];
               lane_we[j]  = accept && (req_act == ACT_WRITE_MEM) && ma_ok
                             && (ma_ext[2:0] == 3'(j));
            end
            S_MEM: begin
               // lanes below the start offset hold the bytes of the next row
               lane_row[j] = (3'(j) < off) ? row_next : row;
               lane_wd[j]  = st_data[{3'(j) - off, 3'b000} +: 8];
               lane_we[j]  = !is_load && !fault && (size8 || !((3'(j) - off) >= 3'd4));
            end
            default: begin
               lane_we[j] = 1'b0;
            end
         endcase
      end
   end

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [7:0] lane_mem [ROWS];

      always_ff @(posedge clock) begin
         if (lane_we[j]) begin
            lane_mem[lane_row[j]] <= lane_wd[j];
         end
         lane_rd_ff[j] <= lane_mem[lane_row[j]];
      end
   end

   // sequencer and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_row_ff <= '0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clear_row_ff <= clear_row_ff + 1'b1;
               if (clear_row_ff == ROW_W'(ROWS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  ins_ff   <= req_instruction;
                  addr_ff  <= ma_ext;
                  ma_ok_ff <= ma_ok;
                  case (req_act)
                     ACT_EXECUTE: begin
                        state_ff <= S_ADDR;
                     end
                     ACT_READ_REG: begin
                        state_ff <= S_RDREG;
                     end
                     ACT_READ_MEM: begin
                        state_ff <= S_RDMEM;
                     end
                     default: begin
                        // writes and unused codes answer at once
                        rsp_valid_ff      <= 1'b1;
                        rsp_read_value_ff <= '0;
                        rsp_status_ff     <= 1'b0;
                        rsp_pc_value_ff   <= pc_ff;
                     end
                  endcase
               end
            end
            S_ADDR: begin
               addr_ff  <= addr_in;
               moved_ff <= moved;
               fwd_ff   <= wb && (ins_ff[4:0] == ins_ff[9:5]) && (ins_ff[9:5] != REG_ZERO);
               pc_ff    <= pc_ff + PC_STEP;
               state_ff <= S_MEM;
            end
            S_MEM: begin
               fault_ff <= fault;
               if (is_load) begin
                  state_ff <= S_LOAD;
               end else begin
                  state_ff          <= S_IDLE;
                  rsp_valid_ff      <= 1'b1;
                  rsp_read_value_ff <= '0;
                  rsp_status_ff     <= fault;
                  rsp_pc_value_ff   <= pc_ff;
               end
            end
            S_LOAD: begin
               state_ff          <= S_IDLE;
               rsp_valid_ff      <= 1'b1;
               rsp_read_value_ff <= '0;
               rsp_status_ff     <= fault_ff;
               rsp_pc_value_ff   <= pc_ff;
            end
            S_RDREG: begin
               state_ff          <= S_IDLE;
               rsp_valid_ff      <= 1'b1;
               rsp_read_value_ff <= a_val;
               rsp_status_ff     <= 1'b0;
               rsp_pc_value_ff   <= pc_ff;
            end
            S_RDMEM: begin
               state_ff          <= S_IDLE;
               rsp_valid_ff      <= 1'b1;
               rsp_read_value_ff <= ma_ok_ff ? {56'b0, lane_rd_ff[addr_ff[2:0]]} : 64'b0;
               rsp_status_ff     <= 1'b0;
               rsp_pc_value_ff   <= pc_ff;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // pc moves by one instruction exactly when the address step runs
   a_pc_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADDR) |=> (pc_ff == $past(pc_ff) + PC_STEP))
      else $error("pc did not advance by one instruction");

   // the load result step never writes memory
   a_load_no_mem_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> (lane_we == '0))
      else $error("memory written during load write back");

   // an executed request keeps the block busy through address and memory steps
   a_exec_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_act == ACT_EXECUTE)) |=> busy ##1 busy)
      else $error("execute request released busy too early");

   // no response while the memory is being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("response during memory clear");

endmodule
